// ===== sv/bwtoc_pkg.sv =====
// Shared types and constants for the BWT occurrence checkpoint interleaver.
package bwtoc_pkg;

    // Number of 2-bit symbols in one packed BWT word.
    localparam int SYMS_PER_WORD = 16;
    // Width of the word position counter within an interval.
    localparam int POS_W         = 8;
    // Depth and pointer width of the queue between front and back.
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = 2;

    // One classified word as it travels from front to back.
    typedef struct packed {
        logic [31:0]      kept;     // word with invalid slots cleared
        logic [3:0][4:0]  inc;      // occurrences of each symbol in this word
        logic             cp_first; // a checkpoint precedes this word
        logic             last;     // final checkpoint follows this word
    } t_entry;

    // Fill status of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Where the back end stands within the current entry.
    typedef enum logic [1:0] {
        PH_PRE,
        PH_WORD,
        PH_POST
    } t_phase;

endpackage

// ===== sv/bwtoc_front.sv =====
// Front end: classifies each input word and counts its valid symbols.
module bwtoc_front
    import bwtoc_pkg::*;
#(
    parameter int CHECKPOINT_INTERVAL = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [31:0] i_bwt_word,
    input  logic [4:0]  i_valid_symbols,
    input  logic        i_last_word,
    output t_entry      o_entry
);

    localparam int WPI_RAW = CHECKPOINT_INTERVAL / SYMS_PER_WORD;
    localparam int WPI     = (WPI_RAW < 1) ? 1 : WPI_RAW;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W:0]   pos_inc;
    logic [4:0]       nvalid;
    logic [1:0]       sym;
    logic [31:0]      kept;
    logic [3:0][4:0]  inc;

    // Saturate the valid count, clear invalid slots and count each symbol.
    always_comb begin
        nvalid = (i_valid_symbols > 5'(SYMS_PER_WORD)) ? 5'(SYMS_PER_WORD)
                                                        : i_valid_symbols;
        kept = '0;
        inc  = '0;
        for (int i = 0; i < SYMS_PER_WORD; i++) begin
            sym = i_bwt_word[30-2*i +: 2];
            if (5'(i) < nvalid) begin
                kept[30-2*i +: 2] = sym;
                inc[sym]          = inc[sym] + 5'd1;
            end
        end
    end

    // Position within the interval; the end of a stream starts a new one.
    always_comb begin
        pos_inc = {1'b0, r_pos} + {{POS_W{1'b0}}, 1'b1};
        if (i_last_word || (pos_inc >= (POS_W+1)'(WPI))) begin
            n_pos = '0;
        end else begin
            n_pos = pos_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    assign o_entry.kept     = kept;
    assign o_entry.inc      = inc;
    assign o_entry.cp_first = (r_pos == '0);
    assign o_entry.last     = i_last_word;

endmodule

// ===== sv/bwtoc_queue.sv =====
// Short queue of classified words between the front and back ends.
module bwtoc_queue
    import bwtoc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;

    // Storage; entries are payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== sv/bwtoc_back.sv =====
// Back end: running counts, checkpoint sequencing and the output register.
module bwtoc_back
    import bwtoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,
    output logic        o_tuser,
    output logic        o_tlast
);

    t_phase      r_phase;
    t_phase      n_phase;
    t_phase      eff_phase;
    logic [2:0]  r_idx;
    logic [2:0]  n_idx;
    logic [63:0] r_counts [4];
    logic [63:0] n_counts [4];

    logic        r_valid;
    logic [31:0] r_data;
    logic        r_cp;
    logic        r_last;

    logic        load;
    logic        step;
    logic [63:0] cnt_sel;
    logic [31:0] g_data;
    logic        g_cp;
    logic        g_last;

    // The output register takes a new word when empty or being drained.
    assign load = !r_valid || i_tready;
    assign step = load && !i_q_stat.empty;

    // An entry without a leading checkpoint goes straight to its word.
    assign eff_phase = ((r_phase == PH_PRE) && !i_head.cp_first) ? PH_WORD : r_phase;

    // Next phase, index and counts.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        for (int s = 0; s < 4; s++) begin
            n_counts[s] = r_counts[s];
        end
        if (step) begin
            case (eff_phase)
                PH_PRE: begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_phase = PH_WORD;
                    end
                end
                PH_WORD: begin
                    for (int s = 0; s < 4; s++) begin
                        n_counts[s] = r_counts[s] + {59'd0, i_head.inc[s]};
                    end
                    n_idx = '0;
                    if (i_head.last) begin
                        n_phase = PH_POST;
                    end else begin
                        n_phase = PH_PRE;
                        o_pop   = 1'b1;
                    end
                end
                PH_POST: begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_phase = PH_PRE;
                        o_pop   = 1'b1;
                        for (int s = 0; s < 4; s++) begin
                            n_counts[s] = '0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_PRE;
                end
            endcase
        end
    end

    // Word produced for the current position.
    always_comb begin
        cnt_sel = r_counts[r_idx[2:1]];
        g_data  = r_idx[0] ? cnt_sel[63:32] : cnt_sel[31:0];
        g_cp    = 1'b1;
        g_last  = 1'b0;
        case (eff_phase)
            PH_PRE: begin
                g_cp = 1'b1;
            end
            PH_WORD: begin
                g_data = i_head.kept;
                g_cp   = 1'b0;
            end
            PH_POST: begin
                g_last = (r_idx == 3'd7);
            end
            default: begin
                g_cp = 1'b1;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE;
            r_idx   <= '0;
            for (int s = 0; s < 4; s++) begin
                r_counts[s] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            for (int s = 0; s < 4; s++) begin
                r_counts[s] <= n_counts[s];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_data <= g_data;
            r_cp   <= g_cp;
            r_last <= g_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_cp;
    assign o_tlast  = r_last;

endmodule

// ===== sv/bwt_occurrence_checkpoint_interleave.sv =====
// Top level of the BWT occurrence checkpoint interleaver.
//
// Packed BWT words (sixteen 2-bit symbols, symbol 0 in the top bits) enter on
// the slave stream; the master stream carries each word with invalid slots
// cleared, preceded by an eight-word occurrence checkpoint at the start of
// every interval of CHECKPOINT_INTERVAL/16 words (at least one), and followed
// by a final checkpoint after the word marked with tlast. A checkpoint gives
// the 64-bit counts of symbols 0 to 3, each low half then high half, with
// tuser set; tlast marks the last checkpoint word of a stream, after which
// the counts restart from zero. The master side sends one word per cycle
// while m_axis_tready is high and the queue holds an entry. The output
// port sets the throughput: a four-entry queue lets the input side run
// ahead at one word per cycle while the queue is not full. No clearing
// pass is needed after reset.
module bwt_occurrence_checkpoint_interleave
    import bwtoc_pkg::*;
#(
    parameter int CHECKPOINT_INTERVAL = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // bwt_word[31:0], valid_symbols[36:32], zero fill
    input  logic        s_axis_tlast,  // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_word[31:0]
    output logic        m_axis_tuser,  // is_checkpoint
    output logic        m_axis_tlast   // last_out
);

    t_entry  f_entry;
    t_entry  q_head;
    t_q_stat q_stat;
    logic    in_accept;
    logic    pop;

    assign s_axis_tready = !q_stat.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    bwtoc_front #(
        .CHECKPOINT_INTERVAL (CHECKPOINT_INTERVAL)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_bwt_word      (s_axis_tdata[31:0]),
        .i_valid_symbols (s_axis_tdata[36:32]),
        .i_last_word     (s_axis_tlast),
        .o_entry         (f_entry)
    );

    bwtoc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bwtoc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

    // The end of a stream is always the last word of a checkpoint.
    a_last_is_checkpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("final word is not a checkpoint word");

    // The queue can never report full and empty together.
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    // An accepted transaction is held in the queue or on the output next cycle.
    a_accept_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (!q_stat.empty || m_axis_tvalid))
        else $error("accepted transaction vanished");

endmodule
